[hdl/tsnr_pkg.sv]
package tsnr_pkg;

	localparam logic [16:0] BATCH_MAX = 17'd65536;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam logic [5:0] DIV_STEPS = 6'd33;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_FLOOR     = 3'd1,
		REG_CEILING   = 3'd2,
		REG_GAIN      = 3'd3,
		REG_PERIOD    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_DIFF,
		BK_MUL,
		BK_UPD
	} bk_state_t;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic signed [15:0] floor_lvl;
		logic signed [15:0] ceiling;
	} cls_cfg_t;

	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] period;
	} bk_cfg_t;

	// one queued job: a closed batch or a tick
	typedef struct packed {
		logic               is_tick;
		logic signed [31:0] n_sum;
		logic [16:0]        n_cnt;
		logic signed [31:0] s_sum;
		logic [16:0]        s_cnt;
	} job_t;

endpackage

[hdl/threshold_snr_estimator_unit.sv]
// Threshold-split SNR estimator. Samples are sorted into noise and signal
// classes and summed as they arrive: push is taken in any cycle in which
// full is low, one word per cycle. Batch closes and one-second ticks go
// into a four-word job queue; full rises only when that queue is full.
// The back end takes jobs in order: a tick is handled in idle; a closed
// batch is fetched, then each class is loaded and, if its count is nonzero,
// run through a 33-step bit-serial divider for the batch mean, then
// difference, multiply and update. A report word is written into a two-word
// result buffer on the tick that ends a period and is read with pop while
// empty is low. Registers are written through wr_en/wr_index/wr_data; the
// user must write them only while the block is idle; it is not enforced.
module threshold_snr_estimator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic signed [15:0] power_db,
	output logic              empty,
	input  logic              pop,
	output logic [14:0]       snr_db
);
	import tsnr_pkg::*;

	cls_cfg_t cls_cfg_q;
	bk_cfg_t  bk_cfg_q;
	job_t     f_job, h_job;
	logic     f_push, q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_cfg_q.threshold <= -16'sd11520;
			cls_cfg_q.floor_lvl <= -16'sd19200;
			cls_cfg_q.ceiling <= -16'sd3840;
			bk_cfg_q.gain <= 16'd66;
			bk_cfg_q.period <= 16'd1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_THRESHOLD: cls_cfg_q.threshold <= $signed(wr_data);
				REG_FLOOR:     cls_cfg_q.floor_lvl <= $signed(wr_data);
				REG_CEILING:   cls_cfg_q.ceiling <= $signed(wr_data);
				REG_GAIN:      bk_cfg_q.gain <= wr_data;
				REG_PERIOD:    bk_cfg_q.period <= wr_data;
				default: ;
			endcase
		end
	end

	tsnr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cls_cfg_q),
		.push     (push),
		.command  (command),
		.power_db (power_db),
		.q_full   (full),
		.q_push   (f_push),
		.q_job    (f_job)
	);

	tsnr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_job  (f_job),
		.q_full  (full),
		.rd      (q_pop),
		.rd_job  (h_job),
		.q_empty (q_empty)
	);

	tsnr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (bk_cfg_q),
		.head    (h_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.snr_db  (snr_db)
	);

endmodule

[hdl/tsnr_front.sv]
module tsnr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tsnr_pkg::cls_cfg_t cfg,
	input  logic              push,
	input  logic [1:0]        command,
	input  logic signed [15:0] power_db,
	input  logic              q_full,
	output logic              q_push,
	output tsnr_pkg::job_t    q_job
);
	import tsnr_pkg::*;

	logic signed [31:0] n_sum_q, s_sum_q, n_sum_nx, s_sum_nx;
	logic [16:0]        n_cnt_q, s_cnt_q, len_q, n_cnt_nx, s_cnt_nx, len_nx;
	logic               is_noise, is_sig, is_sample, closing, take;
	cmd_t               cmd;

	always_comb begin
		cmd = cmd_t'(command);
		take = push && !q_full;
		is_sample = (cmd == CMD_SAMPLE) || (cmd == CMD_CLOSE);
		is_noise = (power_db > cfg.floor_lvl) && (power_db < cfg.threshold);
		is_sig = !is_noise && (power_db >= cfg.threshold) && (power_db < cfg.ceiling);
		n_sum_nx = n_sum_q + (is_noise ? 32'(power_db) : 32'sd0);
		s_sum_nx = s_sum_q + (is_sig ? 32'(power_db) : 32'sd0);
		n_cnt_nx = n_cnt_q + 17'(is_noise);
		s_cnt_nx = s_cnt_q + 17'(is_sig);
		len_nx = len_q + 17'd1;
		closing = is_sample && ((cmd == CMD_CLOSE) || (len_nx == BATCH_MAX));
		q_push = take && (closing || (cmd == CMD_TICK));
		q_job.is_tick = (cmd == CMD_TICK);
		q_job.n_sum = n_sum_nx;
		q_job.n_cnt = n_cnt_nx;
		q_job.s_sum = s_sum_nx;
		q_job.s_cnt = s_cnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_sum_q <= '0;
			s_sum_q <= '0;
			n_cnt_q <= '0;
			s_cnt_q <= '0;
			len_q <= '0;
		end else if (take && is_sample) begin
			if (closing) begin
				n_sum_q <= '0;
				s_sum_q <= '0;
				n_cnt_q <= '0;
				s_cnt_q <= '0;
				len_q <= '0;
			end else begin
				n_sum_q <= n_sum_nx;
				s_sum_q <= s_sum_nx;
				n_cnt_q <= n_cnt_nx;
				s_cnt_q <= s_cnt_nx;
				len_q <= len_nx;
			end
		end
	end

endmodule

[hdl/tsnr_queue.sv]
module tsnr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tsnr_pkg::job_t wr_job,
	output logic           q_full,
	input  logic           rd,
	output tsnr_pkg::job_t rd_job,
	output logic           q_empty
);
	import tsnr_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_wr, do_rd;

	assign q_full = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
		end
	end

endmodule

[hdl/tsnr_back.sv]
module tsnr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tsnr_pkg::bk_cfg_t cfg,
	input  tsnr_pkg::job_t   head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [14:0]      snr_db
);
	import tsnr_pkg::*;

	bk_state_t          state_q, state_d;
	job_t               job_q;
	logic               cls_q, neg_q;
	logic [32:0]        num_q;
	logic [17:0]        rem_q, den_q;
	logic [5:0]         step_q;
	logic signed [33:0] diff_q;
	logic signed [50:0] prod_q;
	logic signed [31:0] n_avg_q, s_avg_q;
	logic [15:0]        ticks_q, ticks_nx, period;

	logic [14:0]        oq_q [2];
	logic               owp_q, orp_q;
	logic [1:0]         ocnt_q;
	logic               oq_room, tick_fire, emit, do_opop;

	logic signed [31:0] cur_sum, cur_avg, avg_new;
	logic [16:0]        cur_cnt;
	logic [31:0]        mag;
	logic [18:0]        rem_sh;
	logic               ge;
	logic signed [16:0] mean;
	logic signed [16:0] gain_s;
	logic signed [50:0] prod_c, inc;
	logic signed [33:0] snr_full, snr_sh;
	logic [14:0]        snr_val;

	assign oq_room = (ocnt_q != 2'd2);
	assign empty = (ocnt_q == 2'd0);
	assign snr_db = oq_q[orp_q];
	assign do_opop = pop && !empty;

	// datapath helpers
	always_comb begin
		cur_sum = cls_q ? job_q.s_sum : job_q.n_sum;
		cur_cnt = cls_q ? job_q.s_cnt : job_q.n_cnt;
		cur_avg = cls_q ? s_avg_q : n_avg_q;
		mag = cur_sum[31] ? 32'(-cur_sum) : 32'(cur_sum);
		rem_sh = {rem_q, num_q[32]};
		ge = (rem_sh >= {1'b0, den_q});
		mean = neg_q ? -$signed({1'b0, num_q[15:0]}) : $signed({1'b0, num_q[15:0]});
		gain_s = $signed({1'b0, cfg.gain});
		prod_c = diff_q * gain_s;
		inc = (prod_q + 51'sd32768) >>> 16;
		avg_new = cur_avg + 32'(inc);
		period = (cfg.period == '0) ? 16'd1 : cfg.period;
		ticks_nx = ticks_q + 16'd1;
		emit = (ticks_nx >= period);
		snr_full = 34'(s_avg_q) - 34'(n_avg_q) + 34'sd32768;
		snr_sh = snr_full >>> 16;
		if (snr_sh < 0) begin
			snr_val = '0;
		end else if (snr_sh > 34'sd32767) begin
			snr_val = 15'h7fff;
		end else begin
			snr_val = snr_sh[14:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && !head.is_tick) begin
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				if (cur_cnt != '0) begin
					state_d = BK_DIV;
				end else if (cls_q) begin
					state_d = BK_IDLE;
				end
			end
			BK_DIV: begin
				if (step_q == DIV_STEPS - 6'd1) begin
					state_d = BK_DIFF;
				end
			end
			BK_DIFF: state_d = BK_MUL;
			BK_MUL:  state_d = BK_UPD;
			BK_UPD:  state_d = cls_q ? BK_IDLE : BK_LOAD;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == BK_IDLE) && !q_empty && (!head.is_tick || oq_room);
		tick_fire = (state_q == BK_IDLE) && !q_empty && head.is_tick && oq_room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_avg_q <= '0;
			s_avg_q <= '0;
			ticks_q <= '0;
			cls_q <= 1'b0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					cls_q <= 1'b0;
					if (tick_fire) begin
						ticks_q <= emit ? 16'd0 : ticks_nx;
					end
				end
				BK_LOAD: begin
					step_q <= '0;
					if (cur_cnt == '0) begin
						cls_q <= 1'b1;
					end
				end
				BK_DIV: step_q <= step_q + 6'd1;
				BK_UPD: begin
					if (cls_q) begin
						s_avg_q <= avg_new;
					end else begin
						n_avg_q <= avg_new;
					end
					cls_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers of the divider and multiplier
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					job_q <= head;
				end
			end
			BK_LOAD: begin
				neg_q <= cur_sum[31];
				num_q <= {mag, 1'b0} + 33'(cur_cnt);
				den_q <= {cur_cnt, 1'b0};
				rem_q <= '0;
			end
			BK_DIV: begin
				rem_q <= ge ? 18'(rem_sh - {1'b0, den_q}) : rem_sh[17:0];
				num_q <= {num_q[31:0], ge};
			end
			BK_DIFF: diff_q <= $signed({mean[16], mean, 16'h0000}) - 34'(cur_avg);
			BK_MUL:  prod_q <= prod_c;
			default: ;
		endcase
	end

	// result buffer: two words so a report can wait while the next job runs
	always_ff @(posedge clk) begin
		if (tick_fire && emit) begin
			oq_q[owp_q] <= snr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (tick_fire && emit) begin
				owp_q <= !owp_q;
			end
			if (do_opop) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + 2'(tick_fire && emit) - 2'(do_opop);
		end
	end

endmodule

[tb/sv/tb_threshold_snr_estimator_unit.sv]
module tb_threshold_snr_estimator_unit;
	import tsnr_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 500;
	localparam int RANDOM_WORDS = 600;
	localparam int PRINT_LIMIT  = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              wr_en = 1'b0;
	reg_idx_t          wr_index = REG_THRESHOLD;
	logic [15:0]       wr_data = '0;
	logic              push = 1'b0;
	logic              full;
	cmd_t              command = CMD_SAMPLE;
	logic signed [15:0] power_db = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [14:0]       snr_db;

	// predictor copy of the registers
	logic signed [15:0] cfg_threshold = -16'sd11520;
	logic signed [15:0] cfg_floor     = -16'sd19200;
	logic signed [15:0] cfg_ceiling   = -16'sd3840;
	logic [15:0]        cfg_gain      = 16'd66;
	logic [15:0]        cfg_period    = 16'd1;

	// predictor copy of the state
	longint      nz_acc = 0;
	longint      sg_acc = 0;
	int          noise_cnt = 0;
	int          signal_cnt = 0;
	int          batch_len = 0;
	longint      noise_avg = 0;
	longint      signal_avg = 0;
	int unsigned tick_cnt = 0;

	logic [14:0] snr_expected[$];
	logic [14:0] want_snr;

	int  mismatches = 0;
	int  words_sent = 0;
	int  reports_due = 0;
	int  reports_seen = 0;
	int  held_cycles = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	int  rx_stall = 0;
	int  phases = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;

	threshold_snr_estimator_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.full     (full),
		.command  (command),
		.power_db (power_db),
		.empty    (empty),
		.pop      (pop),
		.snr_db   (snr_db)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
				snr_expected.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [14:0] got, logic [14:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
	endtask

	// result side: compare every popped word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (snr_expected.size() == 0) begin
				report_mismatch("report word with none expected, snr_db", snr_db, '0);
			end else begin
				want_snr = snr_expected.pop_front();
				reports_seen++;
				if (snr_db !== want_snr)
					report_mismatch("snr_db", snr_db, want_snr);
			end
		end
		if (push && full)
			held_cycles++;
	end

	function automatic int gap_len(bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: long hold-offs first, then random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				rx_stall = gap_len(rx_idle_on);
			end
		end
	end

	// batch mean, halves away from zero
	function automatic longint rounded_mean(longint sum, int cnt);
		longint mag, q;
		mag = (sum < 0) ? -sum : sum;
		q = (2 * mag + cnt) / (2 * longint'(cnt));
		return (sum < 0) ? -q : q;
	endfunction

	// avg += alpha * (mean - avg), halves towards plus infinity
	function automatic longint fold_mean(longint avg, longint mean);
		longint prod;
		prod = (mean * 65536 - avg) * longint'(cfg_gain);
		return avg + ((prod + 32768) >>> 16);
	endfunction

	task automatic predict_snr(cmd_t c, logic signed [15:0] p);
		int          pv;
		int unsigned span;
		longint      d;
		pv = p;
		case (c)
			CMD_SAMPLE, CMD_CLOSE: begin
				if (pv > cfg_floor && pv < cfg_threshold) begin
					nz_acc += pv;
					noise_cnt++;
				end else if (pv >= cfg_threshold && pv < cfg_ceiling) begin
					sg_acc += pv;
					signal_cnt++;
				end
				batch_len++;
				if (c == CMD_CLOSE || batch_len >= int'(BATCH_MAX)) begin
					if (noise_cnt != 0)
						noise_avg = fold_mean(noise_avg, rounded_mean(nz_acc, noise_cnt));
					if (signal_cnt != 0)
						signal_avg = fold_mean(signal_avg, rounded_mean(sg_acc, signal_cnt));
					nz_acc = 0;
					sg_acc = 0;
					noise_cnt = 0;
					signal_cnt = 0;
					batch_len = 0;
				end
			end
			CMD_TICK: begin
				span = (cfg_period == 0) ? 1 : cfg_period;
				tick_cnt = (tick_cnt + 1) & 32'hFFFF;
				if (tick_cnt >= span) begin
					tick_cnt = 0;
					d = (signal_avg - noise_avg + 32768) >>> 16;
					if (d < 0)
						d = 0;
					if (d > 32767)
						d = 32767;
					snr_expected.push_back(d[14:0]);
					reports_due++;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(cmd_t c, logic signed [15:0] p);
		int gap;
		@(negedge clk);
		push <= 1'b1;
		command <= c;
		power_db <= p;
		do @(posedge clk); while (full);
		predict_snr(c, p);
		words_sent++;
		gap = gap_len(tx_idle_on);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// wait for every report, then for the back end to finish queued batches
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (snr_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_THRESHOLD: cfg_threshold = val;
			REG_FLOOR:     cfg_floor = val;
			REG_CEILING:   cfg_ceiling = val;
			REG_GAIN:      cfg_gain = val;
			REG_PERIOD:    cfg_period = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] th, fl, ce, gn, pe);
		write_reg(REG_THRESHOLD, th);
		write_reg(REG_FLOOR, fl);
		write_reg(REG_CEILING, ce);
		write_reg(REG_GAIN, gn);
		write_reg(REG_PERIOD, pe);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_power();
		int lo, hi, v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: begin
				case ($urandom_range(0, 2))
					0:       v = cfg_floor;
					1:       v = cfg_threshold;
					default: v = cfg_ceiling;
				endcase
				v = v + int'($urandom_range(0, 2)) - 1;
			end
			default: begin
				lo = int'(cfg_floor) - 2;
				hi = int'(cfg_ceiling) + 2;
				if (lo > hi) begin
					v = lo;
					lo = hi;
					hi = v;
				end
				v = lo + int'($urandom_range(0, hi - lo));
			end
		endcase
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return 16'(v);
	endfunction

	// class boundaries at reset values and at the extremes, rounding halves
	task automatic test_class_edges();
		send_word(CMD_SAMPLE, -16'sd19200);
		send_word(CMD_SAMPLE, -16'sd19199);
		send_word(CMD_SAMPLE, -16'sd11521);
		send_word(CMD_SAMPLE, -16'sd11520);
		send_word(CMD_SAMPLE, -16'sd3841);
		send_word(CMD_SAMPLE, -16'sd3840);
		send_word(CMD_NONE, 16'sd32767);
		send_word(CMD_CLOSE, -16'sd32768);
		send_word(CMD_TICK, 16'sd0);
		// batch with neither class present keeps both averages
		send_word(CMD_CLOSE, 16'sd32767);
		send_word(CMD_TICK, -16'sd1);
		wait_idle();

		set_config(16'sd0, -16'sd32768, 16'sd32767, 16'd65535, 16'd1);
		send_word(CMD_SAMPLE, -16'sd32768);
		send_word(CMD_SAMPLE, -16'sd32767);
		send_word(CMD_SAMPLE, 16'sd0);
		send_word(CMD_SAMPLE, 16'sd32766);
		send_word(CMD_CLOSE, 16'sd32767);
		send_word(CMD_TICK, 16'sd0);
		// halves in the batch mean: -1.5 and +1.5
		send_word(CMD_SAMPLE, -16'sd1);
		send_word(CMD_CLOSE, -16'sd2);
		send_word(CMD_SAMPLE, 16'sd1);
		send_word(CMD_CLOSE, 16'sd2);
		send_word(CMD_TICK, 16'sd0);
		wait_idle();

		// empty noise band, signal band everything below the top
		set_config(-16'sd32768, -16'sd32768, 16'sd32767, 16'd1, 16'd1);
		send_word(CMD_SAMPLE, -16'sd32768);
		send_word(CMD_CLOSE, 16'sd12345);
		send_word(CMD_TICK, 16'sd0);
		wait_idle();

		// bands inverted: nothing classified
		set_config(16'sd32767, 16'sd32767, -16'sd32768, 16'd32768, 16'd1);
		send_word(CMD_SAMPLE, 16'sd32767);
		send_word(CMD_CLOSE, -16'sd32768);
		send_word(CMD_TICK, 16'sd0);
		wait_idle();
	endtask

	task automatic test_report_period();
		tx_idle_on = 1'b0;
		set_config(16'sd0, -16'sd32768, 16'sd32767, 16'd20000, 16'd0);
		send_word(CMD_SAMPLE, 16'sd3000);
		send_word(CMD_CLOSE, -16'sd3000);
		repeat (3) send_word(CMD_TICK, 16'sd0);
		wait_idle();
		set_config(16'sd0, -16'sd32768, 16'sd32767, 16'd20000, 16'd3);
		repeat (7) send_word(CMD_TICK, 16'sd0);
		wait_idle();
		// longest period: a few ticks and no report
		set_config(16'sd0, -16'sd32768, 16'sd32767, 16'd20000, 16'd65535);
		repeat (4) send_word(CMD_TICK, 16'sd0);
		wait_idle();
		tx_idle_on = 1'b1;
	endtask

	// hold pop off so reports back up into the job queue and full rises
	task automatic test_backpressure();
		set_config(-16'sd100, -16'sd20000, 16'sd20000, 16'd40000, 16'd1);
		hold_left = 800;
		repeat (12) begin
			send_word(CMD_SAMPLE, pick_power());
			send_word(CMD_CLOSE, pick_power());
			send_word(CMD_TICK, 16'sd0);
		end
		wait_idle();
	endtask

	task automatic test_random();
		int base, fl, th, ce, r;
		logic [15:0] gn, pe;
		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			if ($urandom_range(0, 4) == 0) begin
				fl = int'($urandom_range(0, 65535)) - 32768;
				th = int'($urandom_range(0, 65535)) - 32768;
				ce = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				fl = -32768 + int'($urandom_range(0, 32768));
				th = fl + int'($urandom_range(1, 16000));
				ce = th + int'($urandom_range(1, 16000));
				if (th > 32767)
					th = 32767;
				if (ce > 32767)
					ce = 32767;
			end
			r = $urandom_range(0, 99);
			gn = (r < 15) ? 16'd1 : (r < 30) ? 16'd65535 : 16'($urandom_range(1, 65535));
			r = $urandom_range(0, 99);
			pe = (r < 10) ? 16'd0 : (r < 80) ? 16'($urandom_range(1, 3)) :
				16'($urandom_range(4, 8));
			set_config(16'(th), 16'(fl), 16'(ce), gn, pe);
			tx_idle_on = (phases % 3) != 0;
			rx_idle_on = (phases % 4) != 1;
			repeat (100) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_word(CMD_NONE, 16'($urandom));
				else if (r < 14)
					send_word(CMD_TICK, 16'($urandom));
				else if (r < 26)
					send_word(CMD_CLOSE, pick_power());
				else
					send_word(CMD_SAMPLE, pick_power());
			end
			wait_idle();
			phases++;
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_class_edges();
		test_report_period();
		test_backpressure();
		test_random();
		@(negedge clk);
		push <= 1'b0;
		while (snr_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered: %0d words over class edges, report periods, back-pressure and",
			words_sent);
		$display("covered: %0d random phases; %0d of %0d reports checked, %0d cycles full",
			phases, reports_seen, reports_due, held_cycles);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[threshold_snr_estimator_unit.f]
hdl/tsnr_pkg.sv
hdl/tsnr_front.sv
hdl/tsnr_queue.sv
hdl/tsnr_back.sv
hdl/threshold_snr_estimator_unit.sv
tb/sv/tb_threshold_snr_estimator_unit.sv
